/* rtl/dfs_pkg.sv */
// Shared types and constants for the depth-first topological sort block.
package dfs_pkg;
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 256;
  localparam int unsigned VW = $clog2(MaxVertices);
  localparam int unsigned EW = $clog2(MaxEdges);
  localparam int unsigned CW = $clog2(MaxVertices) + 1;
  localparam int unsigned HW = $clog2(MaxEdges) + 1;

  typedef enum logic [1:0] {
    CmdAdd   = 2'd0,
    CmdSort  = 2'd1,
    CmdClear = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindEdgeAck  = 2'd0,
    KindVertex   = 2'd1,
    KindClearAck = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    StIdle,
    StVclr,
    StRoot,
    StTopRd,
    StTopWt,
    StScan,
    StPush,
    StPop,
    StEmitRd,
    StEmitWt,
    StOut
  } state_e;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [VW-1:0] src_vertex;
    logic [VW-1:0] dst_vertex;
  } in_word_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic          status;
    logic [VW-1:0] vertex;
    logic          last;
  } out_word_t;
endpackage

/* rtl/dfs_if.sv */
// Valid/ready channel carrying one payload word.
interface dfs_in_if;
  logic               valid;
  logic               ready;
  dfs_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dfs_out_if;
  logic               valid;
  logic               ready;
  dfs_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/dfs_edge_ram.sv */
// Edge store: from/to pairs, one write port, one registered read port.
module dfs_edge_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [dfs_pkg::EW-1:0]    waddr_i,
  input  logic [dfs_pkg::VW-1:0]    wfrom_i,
  input  logic [dfs_pkg::VW-1:0]    wto_i,
  input  logic [dfs_pkg::EW-1:0]    raddr_i,
  output logic [dfs_pkg::VW-1:0]    rfrom_o,
  output logic [dfs_pkg::VW-1:0]    rto_o
);
  logic [2*dfs_pkg::VW-1:0] mem [dfs_pkg::MaxEdges];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wfrom_i, wto_i};
    end
    {rfrom_o, rto_o} <= mem[raddr_i];
  end
endmodule

/* rtl/dfs_stack_ram.sv */
// Walk stack and finish list memory (vertex, next edge position).
module dfs_stack_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [dfs_pkg::VW-1:0]    waddr_i,
  input  logic [dfs_pkg::VW-1:0]    wvert_i,
  input  logic [dfs_pkg::HW-1:0]    wpos_i,
  input  logic [dfs_pkg::VW-1:0]    raddr_i,
  output logic [dfs_pkg::VW-1:0]    rvert_o,
  output logic [dfs_pkg::HW-1:0]    rpos_o,
  input  logic                      fwe_i,
  input  logic [dfs_pkg::VW-1:0]    faddr_w_i,
  input  logic [dfs_pkg::VW-1:0]    fdata_i,
  input  logic [dfs_pkg::VW-1:0]    faddr_r_i,
  output logic [dfs_pkg::VW-1:0]    fdata_o
);
  logic [dfs_pkg::VW+dfs_pkg::HW-1:0] stk [dfs_pkg::MaxVertices];
  logic [dfs_pkg::VW-1:0]             fin [dfs_pkg::MaxVertices];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      stk[waddr_i] <= {wvert_i, wpos_i};
    end
    {rvert_o, rpos_o} <= stk[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (fwe_i) begin
      fin[faddr_w_i] <= fdata_i;
    end
    fdata_o <= fin[faddr_r_i];
  end
endmodule

/* rtl/dfs_topological_order_core.sv */
// Top level: command decode, edge load and depth-first sort sequencer.
//
// channel  dir  payload                              accept
// in_if    in   cmd, src_vertex, dst_vertex          valid & ready
// out_if   out  kind, status, vertex, last           valid & ready
// cfg      in   vertex_count (7b)                    cfg_we_i
//
// Add and clear: the result word follows in the next cycle; the next word is taken
// only once that result drains.
// Sort: the edge memory read port sets the pace of the walk, one edge a cycle
// while no edge to an unvisited vertex is found.
// Each vertex emitted passes StEmitRd, StEmitWt, StOut; output stalls hold StOut.
// Reset empties the edge store and sets vertex_count to 64; no clearing pass.
module dfs_topological_order_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  dfs_in_if.sink    in_if,
  dfs_out_if.source out_if
);
  localparam int unsigned VW = dfs_pkg::VW;
  localparam int unsigned HW = dfs_pkg::HW;
  localparam int unsigned CW = dfs_pkg::CW;
  localparam int unsigned EW = dfs_pkg::EW;

  dfs_pkg::state_e state_q, state_d;
  logic [6:0]    vcount_q;
  logic [HW-1:0] held_q, held_d;
  logic [dfs_pkg::MaxVertices-1:0] vis_q, vis_d;
  logic [CW-1:0] root_q, root_d;
  logic [CW-1:0] depth_q, depth_d;
  logic [CW-1:0] fin_q, fin_d;
  logic [VW-1:0] curv_q, curv_d;
  logic [HW-1:0] pos_q, pos_d;
  dfs_pkg::out_word_t out_q, out_d;
  logic          ovalid_q, ovalid_d;

  logic [CW-1:0] n;
  assign n = (vcount_q > 7'(dfs_pkg::MaxVertices)) ? CW'(dfs_pkg::MaxVertices)
                                                   : CW'(vcount_q);

  logic          ewe;
  logic [EW-1:0] eraddr;
  logic [VW-1:0] efrom, eto;
  logic          swe;
  logic [VW-1:0] swaddr, swvert, sraddr, srvert;
  logic [HW-1:0] swpos, srpos;
  logic          fwe;
  logic [VW-1:0] fraddr, frdata;

  dfs_edge_ram u_edge (
    .clk_i, .we_i(ewe), .waddr_i(held_q[EW-1:0]),
    .wfrom_i(in_if.data.src_vertex), .wto_i(in_if.data.dst_vertex),
    .raddr_i(eraddr), .rfrom_o(efrom), .rto_o(eto)
  );

  dfs_stack_ram u_stack (
    .clk_i, .we_i(swe), .waddr_i(swaddr), .wvert_i(swvert), .wpos_i(swpos),
    .raddr_i(sraddr), .rvert_o(srvert), .rpos_o(srpos),
    .fwe_i(fwe), .faddr_w_i(fin_q[VW-1:0]), .fdata_i(curv_q),
    .faddr_r_i(fraddr), .fdata_o(frdata)
  );

  logic acc_in;
  assign acc_in   = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == dfs_pkg::StIdle) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = out_q;

  logic scan_more, hit;
  assign scan_more = pos_q < held_q;
  assign hit = (efrom == curv_q) && (CW'(eto) < n) && !vis_q[eto];

  always_comb begin
    state_d = state_q;
    case (state_q)
      dfs_pkg::StIdle: begin
        if (acc_in && in_if.data.cmd == dfs_pkg::CmdSort) begin
          state_d = dfs_pkg::StVclr;
        end
      end
      dfs_pkg::StVclr: state_d = dfs_pkg::StRoot;
      dfs_pkg::StRoot: begin
        if (root_q >= n) begin
          state_d = (fin_q == '0) ? dfs_pkg::StIdle : dfs_pkg::StEmitRd;
        end else if (!vis_q[root_q[VW-1:0]]) begin
          state_d = dfs_pkg::StScan;
        end
      end
      dfs_pkg::StTopRd: state_d = dfs_pkg::StTopWt;
      dfs_pkg::StTopWt: state_d = dfs_pkg::StScan;
      dfs_pkg::StScan: begin
        if (!scan_more) begin
          state_d = dfs_pkg::StPop;
        end else begin
          state_d = dfs_pkg::StPush;
        end
      end
      dfs_pkg::StPush: begin
        if (hit) begin
          state_d = dfs_pkg::StScan;
        end else if (!scan_more) begin
          state_d = dfs_pkg::StPop;
        end
      end
      dfs_pkg::StPop: state_d = (depth_q == CW'(1)) ? dfs_pkg::StRoot : dfs_pkg::StTopRd;
      dfs_pkg::StEmitRd: state_d = dfs_pkg::StEmitWt;
      dfs_pkg::StEmitWt: state_d = dfs_pkg::StOut;
      dfs_pkg::StOut: begin
        if (!ovalid_q || out_if.ready) begin
          state_d = (fin_q == CW'(1)) ? dfs_pkg::StIdle : dfs_pkg::StEmitRd;
        end
      end
      default: state_d = dfs_pkg::StIdle;
    endcase
  end

  // StScan issues the edge read at pos; StPush sees the data, advances pos and
  // issues the next read so a scan sustains one edge a cycle until an edge hits an unvisited vertex.
  always_comb begin
    held_d = held_q; vis_d = vis_q; root_d = root_q; depth_d = depth_q;
    fin_d = fin_q; curv_d = curv_q; pos_d = pos_q;
    out_d = out_q; ovalid_d = ovalid_q;
    ewe = 1'b0; eraddr = pos_q[EW-1:0];
    swe = 1'b0; swaddr = '0; swvert = curv_q; swpos = pos_q;
    sraddr = VW'(depth_q - CW'(1));
    fwe = 1'b0; fraddr = VW'(fin_q - CW'(1));
    if (ovalid_q && out_if.ready) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      dfs_pkg::StIdle: begin
        if (acc_in) begin
          out_d = '0;
          out_d.last = 1'b1;
          case (in_if.data.cmd)
            dfs_pkg::CmdAdd: begin
              ovalid_d = 1'b1;
              out_d.kind = dfs_pkg::KindEdgeAck;
              if (CW'(in_if.data.src_vertex) >= n || CW'(in_if.data.dst_vertex) >= n ||
                  held_q >= HW'(dfs_pkg::MaxEdges)) begin
                out_d.status = 1'b1;
              end else begin
                ewe = 1'b1;
                held_d = held_q + HW'(1);
              end
            end
            dfs_pkg::CmdClear: begin
              ovalid_d = 1'b1;
              out_d.kind = dfs_pkg::KindClearAck;
              held_d = '0;
            end
            default: ;
          endcase
        end
      end
      dfs_pkg::StVclr: begin
        vis_d = '0; root_d = '0; fin_d = '0; depth_d = '0;
      end
      dfs_pkg::StRoot: begin
        if (root_q < n) begin
          root_d = root_q + CW'(1);
          if (!vis_q[root_q[VW-1:0]]) begin
            vis_d[root_q[VW-1:0]] = 1'b1;
            curv_d = root_q[VW-1:0];
            pos_d = '0;
            depth_d = CW'(1);
          end
        end
      end
      dfs_pkg::StTopWt: begin
        curv_d = srvert;
        pos_d = srpos;
      end
      dfs_pkg::StScan: begin
        eraddr = pos_q[EW-1:0];
        if (scan_more) begin
          pos_d = pos_q + HW'(1);
        end
      end
      dfs_pkg::StPush: begin
        if (hit) begin
          swe = 1'b1;
          swaddr = VW'(depth_q - CW'(1));
          vis_d[eto] = 1'b1;
          if (depth_q < CW'(dfs_pkg::MaxVertices)) begin
            depth_d = depth_q + CW'(1);
            curv_d = eto;
            pos_d = '0;
          end
        end else begin
          eraddr = pos_q[EW-1:0];
          if (scan_more) begin
            pos_d = pos_q + HW'(1);
          end
        end
      end
      dfs_pkg::StPop: begin
        if (fin_q < CW'(dfs_pkg::MaxVertices)) begin
          fwe = 1'b1;
          fin_d = fin_q + CW'(1);
        end
        depth_d = depth_q - CW'(1);
        sraddr = VW'(depth_q - CW'(2));
      end
      dfs_pkg::StTopRd: sraddr = VW'(depth_q - CW'(1));
      dfs_pkg::StEmitRd: fraddr = VW'(fin_q - CW'(1));
      dfs_pkg::StEmitWt: ;
      dfs_pkg::StOut: begin
        if (!ovalid_q || out_if.ready) begin
          ovalid_d = 1'b1;
          out_d.kind = dfs_pkg::KindVertex;
          out_d.status = 1'b0;
          out_d.vertex = frdata;
          out_d.last = (fin_q == CW'(1));
          fin_d = fin_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfs_pkg::StIdle;
      vcount_q <= 7'd64;
      held_q <= '0;
      vis_q <= '0;
      root_q <= '0;
      depth_q <= '0;
      fin_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      held_q <= held_d;
      vis_q <= vis_d;
      root_q <= root_d;
      depth_q <= depth_d;
      fin_q <= fin_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    curv_q <= curv_d;
    pos_q <= pos_d;
    out_q <= out_d;
  end
endmodule

/* rtl/dfs_checker.sv */
// Port-level checker for the topological sort block, bound to the top level.
module dfs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input dfs_pkg::out_word_t out_data_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind != dfs_pkg::KindVertex |-> out_data_i.last)
    else $error("acknowledge without last");

  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind != dfs_pkg::KindVertex |-> out_data_i.vertex == '0)
    else $error("acknowledge with nonzero vertex");

  a_vertex_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == dfs_pkg::KindVertex |-> !out_data_i.status)
    else $error("vertex word with status set");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken while a result is pending");
endmodule

bind dfs_topological_order_core dfs_checker u_dfs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);
